@@ rtl/core/gepc_pkg.sv @@
// Shared types and constants for the grid exit path counter.
// Depends on nothing; used by every module of the block.
`default_nettype none

package gepc_pkg;

  localparam int unsigned COUNT_W = 30;
  localparam int unsigned FIELD_W = 7;
  localparam int unsigned START_W = 6;

  localparam logic [COUNT_W-1:0] PATH_MOD = COUNT_W'(1000000007);

  // One neighbor term travelling from the read issue to the accumulator.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic outside;
    logic sel;
  } gepc_tag_t;

endpackage

`default_nettype wire

@@ rtl/core/gepc_plane_ram.sv @@
// One plane of per-cell counts: one write port, one registered read port.
// Depends on gepc_pkg for the count width.
`default_nettype none

module gepc_plane_ram import gepc_pkg::*; #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [AddrW-1:0]   waddr_i,
  input  wire logic [COUNT_W-1:0] wdata_i,
  input  wire logic [AddrW-1:0]   raddr_i,
  output      logic [COUNT_W-1:0] rdata_o
);

  logic [COUNT_W-1:0] mem_q [Depth];
  logic [COUNT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/gepc_accum.sv @@
// Modular accumulator: sums the four neighbor terms of a cell mod 1e9+7.
// Depends on gepc_pkg for the tag type and the modulus.
`default_nettype none

module gepc_accum import gepc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gepc_tag_t          tag_i,
  input  wire logic [COUNT_W-1:0] rdata_i,
  output      logic               wr_en_o,
  output      logic [COUNT_W-1:0] wr_data_o
);

  logic [COUNT_W-1:0] acc_q;
  logic [COUNT_W-1:0] term;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W:0]   sum_raw;
  logic [COUNT_W-1:0] sum_mod;

  always_comb begin
    term    = tag_i.outside ? COUNT_W'(1) : rdata_i;
    base    = tag_i.first ? '0 : acc_q;
    sum_raw = {1'b0, base} + {1'b0, term};
    if (sum_raw >= {1'b0, PATH_MOD}) begin
      sum_raw = sum_raw - {1'b0, PATH_MOD};
    end
    sum_mod = sum_raw[COUNT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.valid) begin
      acc_q <= sum_mod;
    end
  end

  assign wr_en_o   = tag_i.valid && tag_i.last;
  assign wr_data_o = sum_mod;

`ifndef SYNTHESIS
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (wr_data_o < PATH_MOD))
    else $error("cell count out of range");

  a_terms_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_i.valid && !tag_i.first) |-> $past(tag_i.valid) && !$past(tag_i.last))
    else $error("neighbor terms of a cell not contiguous");

  a_first_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_i.valid && $past(tag_i.valid) && !$past(tag_i.last)) |-> !tag_i.first)
    else $error("cell restarted before its last term");
`endif

endmodule

`default_nettype wire

@@ rtl/core/grid_exit_path_counter_top.sv @@
// Top level of the grid exit path counter: sequencer, two ping-pong count planes.
// Depends on gepc_pkg, gepc_plane_ram and gepc_accum.
//
//   channel   ports                                              direction
//   request   start (busy is out), grid_rows_i, grid_cols_i,     in
//             move_budget_i, start_row_i, start_col_i
//   result    result_valid_o, path_count_o                       out
//
// A transfer is taken when start is high and busy is low. A start cell outside
// the grid, or a zero budget, answers in the next cycle. Otherwise the sequencer clears
// the read plane, then sweeps each level one neighbor read at a time through the
// single read port of the plane memory. The result strobe lasts one cycle and
// cannot be stalled. Reset idles the sequencer; plane contents are not cleared.
`default_nettype none

module grid_exit_path_counter_top import gepc_pkg::*; #(
  parameter int unsigned MAX_ROWS  = 64,
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned MAX_MOVES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [FIELD_W-1:0] grid_rows_i,
  input  wire logic [FIELD_W-1:0] grid_cols_i,
  input  wire logic [FIELD_W-1:0] move_budget_i,
  input  wire logic [START_W-1:0] start_row_i,
  input  wire logic [START_W-1:0] start_col_i,
  output      logic               result_valid_o,
  output      logic [COUNT_W-1:0] path_count_o
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned LW    = $clog2(MAX_MOVES + 1);
  localparam int unsigned RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [AW-1:0] RowStep = AW'(MAX_COLS);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_SWEEP = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_FETCH = 6'b010000,
    ST_REPLY = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [RIW-1:0] r_q, r_d;
  logic [CIW-1:0] c_q, c_d;
  logic [1:0]     k_q, k_d;
  logic [AW-1:0]  row_base_q, row_base_d;
  logic [LW-1:0]  lvl_q, lvl_d;
  logic           src_q, src_d;
  logic           valid_q, valid_d;
  gepc_tag_t      tag_q, tag_d;

  logic [RW-1:0]      rows_q, rows_d;
  logic [CW-1:0]      cols_q, cols_d;
  logic [LW-1:0]      moves_q, moves_d;
  logic [START_W-1:0] sr_q, sr_d;
  logic [START_W-1:0] sc_q, sc_d;
  logic [AW-1:0]      waddr_q, waddr_d;
  logic [COUNT_W-1:0] count_q, count_d;

  logic [RW-1:0]      rows_sat;
  logic [CW-1:0]      cols_sat;
  logic [LW-1:0]      moves_sat;
  logic               start_out;
  logic               accept;
  logic               r_last, c_last, cell_last;
  logic [AW-1:0]      cell_addr;
  logic [AW-1:0]      nb_addr;
  logic               nb_out;
  logic [AW-1:0]      final_addr;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;
  logic               we_a, we_b;
  logic [COUNT_W-1:0] rdata_a, rdata_b;
  logic [COUNT_W-1:0] rdata_tag;
  logic               acc_wr_en;
  logic [COUNT_W-1:0] acc_wr_data;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (32'(grid_rows_i) > MAX_ROWS) begin
      rows_sat = RW'(MAX_ROWS);
    end else begin
      rows_sat = RW'(grid_rows_i);
    end
    if (32'(grid_cols_i) > MAX_COLS) begin
      cols_sat = CW'(MAX_COLS);
    end else begin
      cols_sat = CW'(grid_cols_i);
    end
    if (32'(move_budget_i) > MAX_MOVES) begin
      moves_sat = LW'(MAX_MOVES);
    end else begin
      moves_sat = LW'(move_budget_i);
    end
    start_out = (32'(start_row_i) >= 32'(rows_sat)) || (32'(start_col_i) >= 32'(cols_sat));
  end

  assign r_last     = (RW'(r_q) == rows_q - RW'(1));
  assign c_last     = (CW'(c_q) == cols_q - CW'(1));
  assign cell_last  = r_last && c_last;
  assign cell_addr  = row_base_q + AW'(c_q);
  assign final_addr = AW'(32'(sr_q) * MAX_COLS + 32'(sc_q));

  // neighbor order: down, up, right, left
  always_comb begin
    case (k_q)
      2'd0: begin
        nb_out  = r_last;
        nb_addr = cell_addr + RowStep;
      end
      2'd1: begin
        nb_out  = (r_q == '0);
        nb_addr = cell_addr - RowStep;
      end
      2'd2: begin
        nb_out  = c_last;
        nb_addr = cell_addr + AW'(1);
      end
      default: begin
        nb_out  = (c_q == '0);
        nb_addr = cell_addr - AW'(1);
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    row_base_d = row_base_q;
    lvl_d      = lvl_q;
    src_d      = src_q;
    valid_d    = 1'b0;
    rows_d     = rows_q;
    cols_d     = cols_q;
    moves_d    = moves_q;
    sr_d       = sr_q;
    sc_d       = sc_q;
    count_d    = count_q;
    waddr_d    = cell_addr;
    tag_d      = '{valid: 1'b0, first: (k_q == 2'd0), last: (k_q == 2'd3),
                   outside: nb_out, sel: src_q};
    raddr      = nb_addr;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rows_d  = rows_sat;
          cols_d  = cols_sat;
          moves_d = moves_sat;
          sr_d    = start_row_i;
          sc_d    = start_col_i;
          if (start_out || (moves_sat == '0)) begin
            valid_d = 1'b1;
            count_d = start_out ? COUNT_W'(1) : '0;
          end else begin
            state_d    = ST_CLEAR;
            r_d        = '0;
            c_d        = '0;
            k_d        = '0;
            row_base_d = '0;
            lvl_d      = LW'(1);
            src_d      = 1'b0;
          end
        end
      end
      ST_CLEAR, ST_SWEEP: begin
        if (state_q == ST_SWEEP) begin
          tag_d.valid = 1'b1;
          k_d         = k_q + 2'd1;
        end
        if ((state_q == ST_CLEAR) || (k_q == 2'd3)) begin
          if (cell_last) begin
            r_d        = '0;
            c_d        = '0;
            row_base_d = '0;
            state_d    = (state_q == ST_CLEAR) ? ST_SWEEP : ST_DRAIN;
          end else if (c_last) begin
            r_d        = r_q + RIW'(1);
            c_d        = '0;
            row_base_d = row_base_q + RowStep;
          end else begin
            c_d = c_q + CIW'(1);
          end
        end
      end
      ST_DRAIN: begin
        src_d = !src_q;
        if (lvl_q == moves_q) begin
          state_d = ST_FETCH;
        end else begin
          lvl_d   = lvl_q + LW'(1);
          state_d = ST_SWEEP;
        end
      end
      ST_FETCH: begin
        raddr   = final_addr;
        state_d = ST_REPLY;
      end
      ST_REPLY: begin
        count_d = src_q ? rdata_b : rdata_a;
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      r_q        <= '0;
      c_q        <= '0;
      k_q        <= '0;
      row_base_q <= '0;
      lvl_q      <= '0;
      src_q      <= 1'b0;
      valid_q    <= 1'b0;
      tag_q      <= '0;
    end else begin
      state_q    <= state_d;
      r_q        <= r_d;
      c_q        <= c_d;
      k_q        <= k_d;
      row_base_q <= row_base_d;
      lvl_q      <= lvl_d;
      src_q      <= src_d;
      valid_q    <= valid_d;
      tag_q      <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q  <= rows_d;
    cols_q  <= cols_d;
    moves_q <= moves_d;
    sr_q    <= sr_d;
    sc_q    <= sc_d;
    waddr_q <= waddr_d;
    count_q <= count_d;
  end

  assign rdata_tag = tag_q.sel ? rdata_b : rdata_a;

  gepc_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (tag_q),
    .rdata_i   (rdata_tag),
    .wr_en_o   (acc_wr_en),
    .wr_data_o (acc_wr_data)
  );

  // clear writes the read plane; the sweep writes the other one
  always_comb begin
    if (state_q == ST_CLEAR) begin
      we_a    = !src_q;
      we_b    = src_q;
      wr_addr = cell_addr;
      wr_data = '0;
    end else begin
      we_a    = acc_wr_en && tag_q.sel;
      we_b    = acc_wr_en && !tag_q.sel;
      wr_addr = waddr_q;
      wr_data = acc_wr_data;
    end
  end

  gepc_plane_ram #(
    .Depth (Depth),
    .AddrW (AW)
  ) u_plane_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  gepc_plane_ram #(
    .Depth (Depth),
    .AddrW (AW)
  ) u_plane_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  assign result_valid_o = valid_q;
  assign path_count_o   = count_q;

`ifndef SYNTHESIS
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (path_count_o < PATH_MOD))
    else $error("result out of range");

  a_drained_before_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> !tag_q.valid && !acc_wr_en)
    else $error("sweep pipeline not empty at final read");

  a_no_write_in_flight_at_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && $past(state_q) == ST_DRAIN) |-> !tag_q.valid)
    else $error("level started with a write still pending");
`endif

endmodule

`default_nettype wire
